@@ hdl/che_pkg.sv @@
// ----------------------------------------------------------------------------
// che_pkg
// Shared types and constants of the cubic Hermite curve evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package che_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int VALUE_W       = 32;
    localparam int BOUND_W       = 17;
    localparam int CMD_W         = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int NUM_COEF      = 4;

    localparam int K_TWO    = 2;
    localparam int K_THREE  = 3;
    localparam int K_FOUR   = 4;
    localparam int K_SIX    = 6;
    localparam int K_TWELVE = 12;

    typedef enum logic [CMD_W-1:0] {
        CMD_POSITION = 2'd0,
        CMD_VELOCITY = 2'd1,
        CMD_ACCEL    = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_POS  = 3'd0,
        REG_START_VEL  = 3'd1,
        REG_END_POS    = 3'd2,
        REG_END_VEL    = 3'd3,
        REG_CLAMP_LOW  = 3'd4,
        REG_CLAMP_HIGH = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] param_s;
    } t_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      saturated;
    } t_result;

    typedef struct packed {
        logic             valid;
        logic [CMD_W-1:0] command;
    } t_ctl;

endpackage

`default_nettype wire

@@ hdl/che_clamp.sv @@
// ----------------------------------------------------------------------------
// che_clamp
// First pipeline stage: limits the curve parameter to the configured bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module che_clamp #(
    parameter int FRAC_BITS = che_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire che_pkg::t_req                 i_req,
    input  wire logic [che_pkg::BOUND_W-1:0]   i_clamp_low,
    input  wire logic [che_pkg::BOUND_W-1:0]   i_clamp_high,
    output che_pkg::t_ctl                      o_ctl,
    output logic [FRAC_BITS:0]                 o_s
);
    import che_pkg::*;

    localparam int S_W   = FRAC_BITS + 1;
    localparam int CMP_W = VALUE_W + 1;
    localparam logic signed [CMP_W-1:0] ONE_C =
        {{(CMP_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [S_W-1:0] ONE_S = {1'b1, {FRAC_BITS{1'b0}}};

    logic signed [CMP_W-1:0] lo_raw;
    logic signed [CMP_W-1:0] hi_raw;
    logic signed [CMP_W-1:0] lo;
    logic signed [CMP_W-1:0] hi;
    logic signed [CMP_W-1:0] s_ext;
    logic signed [CMP_W-1:0] s_cl;
    logic [S_W-1:0]          n_s;
    logic                    r_valid;
    logic [CMD_W-1:0]        r_cmd;
    logic [S_W-1:0]          r_s;

    always_comb begin
        lo_raw = $signed({{(CMP_W-BOUND_W){1'b0}}, i_clamp_low});
        hi_raw = $signed({{(CMP_W-BOUND_W){1'b0}}, i_clamp_high});
        lo     = (lo_raw > ONE_C) ? ONE_C : lo_raw;
        hi     = (hi_raw > ONE_C) ? ONE_C : hi_raw;
        s_ext  = $signed({i_req.param_s[VALUE_W-1], i_req.param_s});
        priority if (s_ext < lo) begin
            s_cl = lo;
        end else if (s_ext > hi) begin
            s_cl = hi;
        end else begin
            s_cl = s_ext;
        end
        n_s = s_cl[S_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= i_req.command;
        r_s   <= n_s;
    end

    assign o_ctl = '{valid: r_valid, command: r_cmd};
    assign o_s   = r_s;

    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_s <= ONE_S))
        else $error("Clamped parameter is above one.");

endmodule

`default_nettype wire

@@ hdl/che_powers.sv @@
// ----------------------------------------------------------------------------
// che_powers
// Second and third pipeline stages: rounded square and cube of the parameter.
// ----------------------------------------------------------------------------
`default_nettype none

module che_powers #(
    parameter int FRAC_BITS = che_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire che_pkg::t_ctl      i_ctl,
    input  wire logic [FRAC_BITS:0] i_s,
    output che_pkg::t_ctl           o_ctl,
    output logic [FRAC_BITS:0]      o_s,
    output logic [FRAC_BITS:0]      o_s2,
    output logic [FRAC_BITS:0]      o_s3
);
    import che_pkg::*;

    localparam int S_W    = FRAC_BITS + 1;
    localparam int PROD_W = 2 * S_W;
    localparam logic [PROD_W-1:0] HALF =
        {{(PROD_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [S_W-1:0] ONE_S = {1'b1, {FRAC_BITS{1'b0}}};

    logic [PROD_W-1:0] sq;
    logic [PROD_W-1:0] cu;
    logic [S_W-1:0]    n_s2;
    logic [S_W-1:0]    n_s3;
    logic              r_valid2;
    logic              r_valid3;
    logic [CMD_W-1:0]  r_cmd2;
    logic [CMD_W-1:0]  r_cmd3;
    logic [S_W-1:0]    r_s_a;
    logic [S_W-1:0]    r_s_b;
    logic [S_W-1:0]    r_s2_a;
    logic [S_W-1:0]    r_s2_b;
    logic [S_W-1:0]    r_s3;

    always_comb begin
        sq   = PROD_W'(i_s) * PROD_W'(i_s) + HALF;
        n_s2 = sq[FRAC_BITS +: S_W];
        cu   = PROD_W'(r_s2_a) * PROD_W'(r_s_a) + HALF;
        n_s3 = cu[FRAC_BITS +: S_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            r_valid2 <= i_ctl.valid;
            r_valid3 <= r_valid2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd2 <= i_ctl.command;
        r_s_a  <= i_s;
        r_s2_a <= n_s2;
        r_cmd3 <= r_cmd2;
        r_s_b  <= r_s_a;
        r_s2_b <= r_s2_a;
        r_s3   <= n_s3;
    end

    assign o_ctl = '{valid: r_valid3, command: r_cmd3};
    assign o_s   = r_s_b;
    assign o_s2  = r_s2_b;
    assign o_s3  = r_s3;

    a_power_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid3 |-> ((r_s3 <= r_s2_b) && (r_s2_b <= ONE_S)))
        else $error("Cube exceeds square or square exceeds one.");

endmodule

`default_nettype wire

@@ hdl/che_basis.sv @@
// ----------------------------------------------------------------------------
// che_basis
// Fourth pipeline stage: Hermite basis weights for the selected derivative.
// ----------------------------------------------------------------------------
`default_nettype none

module che_basis #(
    parameter int FRAC_BITS = che_pkg::FRAC_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire che_pkg::t_ctl             i_ctl,
    input  wire logic [FRAC_BITS:0]        i_s,
    input  wire logic [FRAC_BITS:0]        i_s2,
    input  wire logic [FRAC_BITS:0]        i_s3,
    output logic                           o_valid,
    output logic signed [FRAC_BITS+4:0]    o_w [che_pkg::NUM_COEF]
);
    import che_pkg::*;

    localparam int S_W = FRAC_BITS + 1;
    localparam int W_W = FRAC_BITS + 5;
    localparam logic signed [W_W-1:0] ONE_W =
        {{(W_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    logic signed [W_W-1:0] s;
    logic signed [W_W-1:0] s2;
    logic signed [W_W-1:0] s3;
    logic signed [W_W-1:0] n_w [NUM_COEF];
    logic signed [W_W-1:0] r_w [NUM_COEF];
    logic                  r_valid;

    always_comb begin
        s  = $signed({{(W_W-S_W){1'b0}}, i_s});
        s2 = $signed({{(W_W-S_W){1'b0}}, i_s2});
        s3 = $signed({{(W_W-S_W){1'b0}}, i_s3});
        unique case (i_ctl.command)
            CMD_POSITION: begin
                n_w[0] = W_W'(K_TWO * s3 - K_THREE * s2 + ONE_W);
                n_w[1] = W_W'(s3 - K_TWO * s2 + s);
                n_w[2] = W_W'(K_THREE * s2 - K_TWO * s3);
                n_w[3] = W_W'(s3 - s2);
            end
            CMD_VELOCITY: begin
                n_w[0] = W_W'(K_SIX * s2 - K_SIX * s);
                n_w[1] = W_W'(K_THREE * s2 - K_FOUR * s + ONE_W);
                n_w[2] = W_W'(K_SIX * s - K_SIX * s2);
                n_w[3] = W_W'(K_THREE * s2 - K_TWO * s);
            end
            CMD_ACCEL: begin
                n_w[0] = W_W'(K_TWELVE * s - K_SIX * ONE_W);
                n_w[1] = W_W'(K_SIX * s - K_FOUR * ONE_W);
                n_w[2] = W_W'(K_SIX * ONE_W - K_TWELVE * s);
                n_w[3] = W_W'(K_SIX * s - K_TWO * ONE_W);
            end
            default: begin
                n_w[0] = '0;
                n_w[1] = '0;
                n_w[2] = '0;
                n_w[3] = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
    end

    assign o_valid = r_valid;
    assign o_w     = r_w;

endmodule

`default_nettype wire

@@ hdl/che_combine.sv @@
// ----------------------------------------------------------------------------
// che_combine
// Stages five to eight: weight products, adder tree, rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module che_combine #(
    parameter int FRAC_BITS = che_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic signed [FRAC_BITS+4:0]       i_w    [che_pkg::NUM_COEF],
    input  wire logic signed [che_pkg::VALUE_W-1:0] i_coef [che_pkg::NUM_COEF],
    output logic                                   o_valid,
    output che_pkg::t_result                       o_result
);
    import che_pkg::*;

    localparam int W_W = FRAC_BITS + 5;
    localparam int P_W = VALUE_W + W_W;
    localparam int A_W = P_W + 2;
    localparam int R_W = A_W - FRAC_BITS;
    localparam logic signed [A_W-1:0] HALF_A =
        {{(A_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [R_W-1:0] MAX_R =
        {{(R_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
    localparam logic signed [R_W-1:0] MIN_R =
        {{(R_W-VALUE_W+1){1'b1}}, {(VALUE_W-1){1'b0}}};

    logic signed [P_W-1:0]     n_p [NUM_COEF];
    logic signed [P_W-1:0]     r_p [NUM_COEF];
    logic signed [A_W-1:0]     r_p01;
    logic signed [A_W-1:0]     r_p23;
    logic signed [A_W-1:0]     acc;
    logic signed [R_W-1:0]     r_r;
    logic signed [VALUE_W-1:0] n_value;
    logic                      n_sat;
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_sat;
    logic                      r_v5;
    logic                      r_v6;
    logic                      r_v7;
    logic                      r_v8;

    always_comb begin
        for (int k = 0; k < NUM_COEF; k++) begin
            n_p[k] = P_W'(i_coef[k]) * P_W'(i_w[k]);
        end
        acc = r_p01 + r_p23 + HALF_A;
        priority if (r_r > MAX_R) begin
            n_value = MAX_R[VALUE_W-1:0];
            n_sat   = 1'b1;
        end else if (r_r < MIN_R) begin
            n_value = MIN_R[VALUE_W-1:0];
            n_sat   = 1'b1;
        end else begin
            n_value = r_r[VALUE_W-1:0];
            n_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            r_v5 <= i_valid;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p     <= n_p;
        r_p01   <= A_W'(r_p[0]) + A_W'(r_p[1]);
        r_p23   <= A_W'(r_p[2]) + A_W'(r_p[3]);
        r_r     <= acc[A_W-1:FRAC_BITS];
        r_value <= n_value;
        r_sat   <= n_sat;
    end

    assign o_valid  = r_v8;
    assign o_result = '{value: r_value, saturated: r_sat};

endmodule

`default_nettype wire

@@ hdl/cubic_hermite_evaluator.sv @@
// ----------------------------------------------------------------------------
// cubic_hermite_evaluator
// Cubic Hermite curve on the unit interval, signed fixed point.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle and never raises o_busy. Each
// request delivers its result on o_result once it has passed every register
// stage, marked by a one-cycle o_done strobe; results keep request order
// and the receiver must take them when they appear. The eight register stages
// are clamp, square, cube, basis weights, four parallel weight multipliers,
// pair sums, rounding and saturation. Configuration writes are always ready
// and must be issued while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_hermite_evaluator #(
    parameter int FRAC_BITS = che_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire che_pkg::t_req                   i_req,
    output logic                                 o_done,
    output che_pkg::t_result                     o_result,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [che_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [che_pkg::VALUE_W-1:0]     i_cfg_data
);
    import che_pkg::*;

    localparam int LATENCY = 8;
    localparam logic [BOUND_W-1:0] CLAMP_HIGH_RST =
        (FRAC_BITS >= BOUND_W) ? {BOUND_W{1'b1}} : BOUND_W'(1 << FRAC_BITS);

    logic                      accept;
    logic signed [VALUE_W-1:0] r_coef [NUM_COEF];
    logic [BOUND_W-1:0]        r_clamp_low;
    logic [BOUND_W-1:0]        r_clamp_high;
    t_ctl                      clamp_ctl;
    logic [FRAC_BITS:0]        clamp_s;
    t_ctl                      pow_ctl;
    logic [FRAC_BITS:0]        pow_s;
    logic [FRAC_BITS:0]        pow_s2;
    logic [FRAC_BITS:0]        pow_s3;
    logic                      basis_valid;
    logic signed [FRAC_BITS+4:0] basis_w [NUM_COEF];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0]    <= '0;
            r_coef[1]    <= '0;
            r_coef[2]    <= '0;
            r_coef[3]    <= '0;
            r_clamp_low  <= '0;
            r_clamp_high <= CLAMP_HIGH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_START_POS:  r_coef[0]    <= $signed(i_cfg_data);
                REG_START_VEL:  r_coef[1]    <= $signed(i_cfg_data);
                REG_END_POS:    r_coef[2]    <= $signed(i_cfg_data);
                REG_END_VEL:    r_coef[3]    <= $signed(i_cfg_data);
                REG_CLAMP_LOW:  r_clamp_low  <= i_cfg_data[BOUND_W-1:0];
                REG_CLAMP_HIGH: r_clamp_high <= i_cfg_data[BOUND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    che_clamp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_clamp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_req       (i_req),
        .i_clamp_low (r_clamp_low),
        .i_clamp_high(r_clamp_high),
        .o_ctl       (clamp_ctl),
        .o_s         (clamp_s)
    );

    che_powers #(
        .FRAC_BITS(FRAC_BITS)
    ) u_powers (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (clamp_ctl),
        .i_s    (clamp_s),
        .o_ctl  (pow_ctl),
        .o_s    (pow_s),
        .o_s2   (pow_s2),
        .o_s3   (pow_s3)
    );

    che_basis #(
        .FRAC_BITS(FRAC_BITS)
    ) u_basis (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (pow_ctl),
        .i_s    (pow_s),
        .i_s2   (pow_s2),
        .i_s3   (pow_s3),
        .o_valid(basis_valid),
        .o_w    (basis_w)
    );

    che_combine #(
        .FRAC_BITS(FRAC_BITS)
    ) u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (basis_valid),
        .i_w     (basis_w),
        .i_coef  (r_coef),
        .o_valid (o_done),
        .o_result(o_result)
    );

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("Accepted request produced no result.");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> ##LATENCY !o_done)
        else $error("Result appeared without a request.");

    a_sat_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.saturated) |->
            ((o_result.value == {1'b0, {(VALUE_W-1){1'b1}}}) ||
             (o_result.value == {1'b1, {(VALUE_W-1){1'b0}}})))
        else $error("Saturated result is not at a 32-bit limit.");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the cubic Hermite curve evaluator. It sets the curve
// registers and the bounds on s, sends position, velocity, acceleration and
// unused-command requests, and checks every result against its own fixed-point evaluation
// of the Hermite basis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import che_pkg::*;

    localparam longint UNIT      = longint'(1) << FRAC_BITS_DEF;
    localparam longint HALF_UNIT = UNIT >>> 1;
    localparam longint VALUE_MAX = (longint'(1) <<< (VALUE_W - 1)) - 1;
    localparam longint VALUE_MIN = -(longint'(1) <<< (VALUE_W - 1));

    localparam int unsigned UNIT_U     = 1 << FRAC_BITS_DEF;
    localparam int unsigned BOUND_TOP  = (1 << BOUND_W) - 1;
    localparam logic [VALUE_W-1:0] QMAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] QMIN = 32'h8000_0000;

    localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam int RANDOM_PHASES   = 13;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int TAIL_CYCLES     = 20;
    localparam int MAX_REPORTS     = 40;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    t_req             i_req;
    logic             o_done;
    t_result          o_result;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [VALUE_W-1:0]   i_cfg_data;

    logic signed [VALUE_W-1:0] curve_p0;
    logic signed [VALUE_W-1:0] curve_v0;
    logic signed [VALUE_W-1:0] curve_p1;
    logic signed [VALUE_W-1:0] curve_v1;
    logic [BOUND_W-1:0]        bound_lo;
    logic [BOUND_W-1:0]        bound_hi;

    t_result pending_results[$];
    logic    start_high;
    logic    steady;
    int      n_errors;
    int      n_requests;
    int      n_checked;
    int      n_saturated;
    int      n_writes;
    int      n_settings;

    cubic_hermite_evaluator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("cubic_hermite_evaluator verification failed");
        $finish;
    end

    function automatic t_result eval_curve(input logic [CMD_W-1:0] cmd,
                                           input logic [VALUE_W-1:0] s_raw);
        t_result res;
        longint  s, lo, hi, sq, cu, acc, rounded;
        longint  w0, w1, w2, w3;
        lo = (longint'(bound_lo) > UNIT) ? UNIT : longint'(bound_lo);
        hi = (longint'(bound_hi) > UNIT) ? UNIT : longint'(bound_hi);
        s = longint'($signed(s_raw));
        if (s < lo) begin
            s = lo;
        end else if (s > hi) begin
            s = hi;
        end
        sq = (s * s + HALF_UNIT) >>> FRAC_BITS_DEF;
        cu = (sq * s + HALF_UNIT) >>> FRAC_BITS_DEF;
        res = '0;
        case (cmd)
            CMD_POSITION: begin
                w0 = 2 * cu - 3 * sq + UNIT;
                w1 = cu - 2 * sq + s;
                w2 = -2 * cu + 3 * sq;
                w3 = cu - sq;
            end
            CMD_VELOCITY: begin
                w0 = 6 * sq - 6 * s;
                w1 = 3 * sq - 4 * s + UNIT;
                w2 = -6 * sq + 6 * s;
                w3 = 3 * sq - 2 * s;
            end
            CMD_ACCEL: begin
                w0 = 12 * s - 6 * UNIT;
                w1 = 6 * s - 4 * UNIT;
                w2 = -12 * s + 6 * UNIT;
                w3 = 6 * s - 2 * UNIT;
            end
            default: begin
                return res;
            end
        endcase
        acc = longint'(curve_p0) * w0 + longint'(curve_v0) * w1 +
              longint'(curve_p1) * w2 + longint'(curve_v1) * w3;
        rounded = (acc + HALF_UNIT) >>> FRAC_BITS_DEF;
        if (rounded > VALUE_MAX) begin
            rounded = VALUE_MAX;
            res.saturated = 1'b1;
        end else if (rounded < VALUE_MIN) begin
            rounded = VALUE_MIN;
            res.saturated = 1'b1;
        end
        res.value = rounded[VALUE_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("MISMATCH at %0t: %s got %0d, wanted %0d", $time, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unrequested result value", o_result.value, 0);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_result.value !== want.value) begin
                    report_mismatch("value", o_result.value, want.value);
                end
                if (o_result.saturated !== want.saturated) begin
                    report_mismatch("saturated", o_result.saturated, want.saturated);
                end
            end
        end
    end

    function automatic int pick_gap();
        int unsigned roll;
        if (steady) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] s);
        int      gap;
        t_result want;
        gap = pick_gap();
        if (gap > 0) begin
            if (start_high) begin
                i_start <= 1'b0;
                start_high = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        start_high     = 1'b1;
        i_req.command <= cmd;
        i_req.param_s <= s;
        do @(posedge i_clk); while (o_busy);
        want = eval_curve(cmd, s);
        pending_results = {pending_results, want};
        n_requests++;
        if (want.saturated) begin
            n_saturated++;
        end
    endtask

    // Stops new requests and waits until every outstanding result is back.
    task automatic settle();
        if (start_high) begin
            i_start <= 1'b0;
            start_high = 1'b0;
        end
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        n_writes++;
        case (idx)
            REG_START_POS:  curve_p0 = data;
            REG_START_VEL:  curve_v0 = data;
            REG_END_POS:    curve_p1 = data;
            REG_END_VEL:    curve_v1 = data;
            REG_CLAMP_LOW:  bound_lo = data[BOUND_W-1:0];
            REG_CLAMP_HIGH: bound_hi = data[BOUND_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_curve(input logic [VALUE_W-1:0] p0, input logic [VALUE_W-1:0] v0,
                              input logic [VALUE_W-1:0] p1, input logic [VALUE_W-1:0] v1,
                              input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi);
        settle();
        write_reg(REG_START_POS, p0);
        write_reg(REG_START_VEL, v0);
        write_reg(REG_END_POS, p1);
        write_reg(REG_END_VEL, v1);
        write_reg(REG_CLAMP_LOW, lo);
        write_reg(REG_CLAMP_HIGH, hi);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Writes to indexes outside the register map must leave the curve alone.
    task automatic poke_spare(input logic [VALUE_W-1:0] data_a, input logic [VALUE_W-1:0] data_b);
        settle();
        write_reg(REG_SPARE_A, data_a);
        write_reg(REG_SPARE_B, data_b);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [VALUE_W-1:0] pick_coef();
        int unsigned mode;
        mode = $urandom_range(0, 19);
        if (mode < 5) begin
            return $urandom;
        end
        if (mode < 11) begin
            return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        end
        if (mode < 14) begin
            return ($urandom_range(0, 1) != 0) ? QMAX : QMIN;
        end
        return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_bound();
        int unsigned mode;
        mode = $urandom_range(0, 19);
        if (mode < 12) begin
            return $urandom_range(0, UNIT_U);
        end
        if (mode < 15) begin
            return mode[0] ? UNIT_U : 0;
        end
        if (mode < 18) begin
            return $urandom_range(UNIT_U + 1, BOUND_TOP);
        end
        return $urandom;
    endfunction

    task automatic test_reset_state();
        send_req(CMD_POSITION, 32'h0000_8000);
        send_req(CMD_ACCEL, QMAX);
    endtask

    task automatic test_basis_commands();
        logic [CMD_W-1:0] cmd;
        load_curve(32'h0001_8000, 32'hFFFE_0000, 32'hFFFF_4000, 32'h0003_4000, 0, UNIT_U);
        for (int c = 0; c < 4; c++) begin
            case (c)
                0:       cmd = CMD_POSITION;
                1:       cmd = CMD_VELOCITY;
                2:       cmd = CMD_ACCEL;
                default: cmd = CMD_UNUSED;
            endcase
            for (int k = 0; k < 3; k++) begin
                send_req(cmd, k * 32'h0000_8000);
            end
        end
    endtask

    task automatic test_saturation();
        load_curve(QMAX, QMAX, QMIN, QMIN, 0, UNIT_U);
        send_req(CMD_VELOCITY, 32'h0000_8000);
        send_req(CMD_ACCEL, 32'h0000_0000);
        send_req(CMD_POSITION, UNIT_U);
        load_curve(QMIN, QMIN, QMAX, QMAX, 0, UNIT_U);
        send_req(CMD_VELOCITY, 32'h0000_8000);
        send_req(CMD_ACCEL, 32'h0000_0000);
    endtask

    task automatic test_clamp_bounds();
        load_curve(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0000_8000,
                   32'h0000_4000, 32'h0000_C000);
        send_req(CMD_POSITION, 32'h0000_0000);
        send_req(CMD_POSITION, QMIN);
        send_req(CMD_VELOCITY, QMAX);
        // A bound register above one is treated as one.
        load_curve(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0000_8000,
                   32'h0000_0000, 32'hFFFF_FFFF);
        send_req(CMD_POSITION, QMAX);
        // With the low bound above the high bound, only s below low gets low.
        load_curve(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0000_8000,
                   32'h0000_C000, 32'h0000_4000);
        send_req(CMD_POSITION, 32'h0000_0000);
        send_req(CMD_POSITION, 32'h0000_8000);
        send_req(CMD_ACCEL, UNIT_U);
        poke_spare($urandom, $urandom);
        send_req(CMD_VELOCITY, 32'h0000_8000);
    endtask

    task automatic test_random_curves();
        logic [VALUE_W-1:0] coef [4];
        logic [VALUE_W-1:0] lo, hi, swap;
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] s;
        int unsigned        roll;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (int k = 0; k < 4; k++) begin
                case (ph)
                    0:       coef[k] = QMAX;
                    1:       coef[k] = k[0] ? QMIN : QMAX;
                    2:       coef[k] = QMIN;
                    default: coef[k] = pick_coef();
                endcase
            end
            lo = pick_bound();
            hi = pick_bound();
            if ((ph == 4 || ph == 9) && lo[BOUND_W-1:0] < hi[BOUND_W-1:0]) begin
                swap = lo;
                lo = hi;
                hi = swap;
            end
            load_curve(coef[0], coef[1], coef[2], coef[3], lo, hi);
            if (ph % 3 == 2) begin
                poke_spare($urandom, $urandom);
            end
            steady = (ph % 4 == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(0, 15);
                if (roll == 0) begin
                    cmd = CMD_UNUSED;
                end else if (roll < 6) begin
                    cmd = CMD_POSITION;
                end else if (roll < 11) begin
                    cmd = CMD_VELOCITY;
                end else begin
                    cmd = CMD_ACCEL;
                end
                roll = $urandom_range(0, 9);
                if (roll < 7) begin
                    s = $urandom_range(0, UNIT_U);
                end else if (roll == 7) begin
                    s = $urandom_range(0, 2 * UNIT_U) - UNIT_U / 2;
                end else begin
                    s = $urandom;
                end
                send_req(cmd, s);
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_req       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        curve_p0    = '0;
        curve_v0    = '0;
        curve_p1    = '0;
        curve_v1    = '0;
        bound_lo    = '0;
        bound_hi    = UNIT_U;
        start_high  = 1'b0;
        steady      = 1'b0;
        n_errors    = 0;
        n_requests  = 0;
        n_checked   = 0;
        n_saturated = 0;
        n_writes    = 0;
        n_settings  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_basis_commands();
        test_saturation();
        test_clamp_bounds();
        test_random_curves();

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests over %0d curve settings and %0d register writes.",
                 n_requests, n_settings, n_writes);
        $display("Checked %0d results, %0d of them clipped to the 32-bit range.",
                 n_checked, n_saturated);
        if (n_errors == 0) begin
            $display("cubic_hermite_evaluator verification clean");
        end else begin
            $display("cubic_hermite_evaluator verification failed");
        end
        $finish;
    end

endmodule
